>>> rtl/tcrv_pkg.sv
package tcrv_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [7:0] POS_LAST = 8'd255;
  localparam logic [7:0] LEV_LAST = 8'd255;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EVAL   = 2'd2,
    OP_IDENT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE,
    S_A_RD, S_A_CHK, S_A_SH_RD, S_A_SH_WR, S_A_WR,
    S_R_RD, S_R_CHK, S_R_SH_RD, S_R_SH_WR,
    S_E_RD, S_E_CHK, S_E_F_RD, S_E_F_CHK, S_E_GO, S_E_WAIT,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    EV_IDLE, EV_DIV, EV_SQ, EV_CUBE, EV_MA, EV_MB, EV_MC, EV_FIN
  } ev_phase_t;

  typedef struct packed {
    logic       start;
    logic [7:0] x;
    logic [7:0] x1;
    logic [7:0] x2;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
  } eval_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } eval_rsp_t;

endpackage

>>> rtl/tcrv_ram.sv
module tcrv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tcrv_eval.sv
module tcrv_eval #(
  parameter int FRAC_BITS = tcrv_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcrv_pkg::eval_req_t req,
  output tcrv_pkg::eval_rsp_t rsp
);
  import tcrv_pkg::*;

  localparam int TW  = FRAC_BITS + 1;
  localparam int CFW = 13;
  localparam int OW  = (FRAC_BITS + 2 > CFW + 1) ? FRAC_BITS + 2 : CFW + 1;
  localparam int SW  = FRAC_BITS + 14;
  localparam int DCW = $clog2(FRAC_BITS + 1);

  ev_phase_t ph_r, ph_nxt;
  logic [DCW-1:0] dc_r, dc_nxt;
  logic [7:0] range_r, range_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [TW-1:0] q_r, q_nxt;
  logic [TW-1:0] t2_r, t2_nxt;
  logic [TW-1:0] t3_r, t3_nxt;
  logic signed [CFW-1:0] ca_r, cb_r, cc_r, cd_r;
  logic signed [CFW-1:0] ca_nxt, cb_nxt, cc_nxt, cd_nxt;
  logic signed [SW-1:0] acc_r, acc_nxt;
  logic done_r, done_nxt;
  logic [7:0] val_r, val_nxt;

  logic [7:0] rng_v, diff_v;
  logic [8:0] rem2_v;
  logic ge_v;
  logic signed [OW-1:0] ma, mb;
  logic signed [2*OW-1:0] prod;
  logic signed [SW-1:0] s_v;
  logic signed [CFW-1:0] e0, e1, e2, e3;

  function automatic logic signed [OW-1:0] ext_c(input logic signed [CFW-1:0] c);
    ext_c = {{(OW-CFW){c[CFW-1]}}, c};
  endfunction

  function automatic logic signed [OW-1:0] ext_t(input logic [TW-1:0] t);
    ext_t = {{(OW-TW){1'b0}}, t};
  endfunction

  assign rng_v = (req.x2 > req.x1) ? req.x2 - req.x1 : 8'd0;
  assign diff_v = (req.x <= req.x1) ? 8'd0 :
                  ((req.x - req.x1 > rng_v) ? rng_v : req.x - req.x1);
  assign rem2_v = {rem_r, 1'b0};
  assign ge_v = (range_r != 8'd0) && (rem2_v >= {1'b0, range_r});

  assign e0 = CFW'(req.p0);
  assign e1 = CFW'(req.p1);
  assign e2 = CFW'(req.p2);
  assign e3 = CFW'(req.p3);

  always_comb begin
    case (ph_r)
      EV_SQ:   begin ma = ext_t(q_r);   mb = ext_t(q_r); end
      EV_CUBE: begin ma = ext_t(t2_r);  mb = ext_t(q_r); end
      EV_MA:   begin ma = ext_c(ca_r);  mb = ext_t(t3_r); end
      EV_MB:   begin ma = ext_c(cb_r);  mb = ext_t(t2_r); end
      EV_MC:   begin ma = ext_c(cc_r);  mb = ext_t(q_r); end
      default: begin ma = '0;           mb = '0; end
    endcase
  end

  assign prod = ma * mb;
  assign s_v = acc_r + (SW'(cd_r) <<< FRAC_BITS) + (SW'(1) <<< FRAC_BITS);

  always_comb begin
    ph_nxt = ph_r;
    dc_nxt = dc_r;
    range_nxt = range_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    t2_nxt = t2_r;
    t3_nxt = t3_r;
    ca_nxt = ca_r;
    cb_nxt = cb_r;
    cc_nxt = cc_r;
    cd_nxt = cd_r;
    acc_nxt = acc_r;
    done_nxt = 1'b0;
    val_nxt = val_r;
    case (ph_r)
      EV_IDLE: begin
        if (req.start) begin
          range_nxt = rng_v;
          if (rng_v != 8'd0 && diff_v == rng_v) begin
            q_nxt = TW'(1);
            rem_nxt = 8'd0;
          end else begin
            q_nxt = '0;
            rem_nxt = diff_v;
          end
          dc_nxt = '0;
          // doubled Catmull-Rom coefficients
          ca_nxt = CFW'(3 * e1 - 3 * e2 - e0 + e3);
          cb_nxt = CFW'(4 * e2 + 2 * e0 - 5 * e1 - e3);
          cc_nxt = e2 - e0;
          cd_nxt = CFW'(2 * e1);
          ph_nxt = EV_DIV;
        end
      end
      EV_DIV: begin
        rem_nxt = ge_v ? 8'(rem2_v - {1'b0, range_r}) : rem2_v[7:0];
        q_nxt = {q_r[TW-2:0], ge_v};
        dc_nxt = dc_r + DCW'(1);
        if (dc_r == DCW'(FRAC_BITS - 1)) begin
          ph_nxt = EV_SQ;
        end
      end
      EV_SQ: begin
        t2_nxt = prod[FRAC_BITS +: TW];
        ph_nxt = EV_CUBE;
      end
      EV_CUBE: begin
        t3_nxt = prod[FRAC_BITS +: TW];
        ph_nxt = EV_MA;
      end
      EV_MA: begin
        acc_nxt = prod[SW-1:0];
        ph_nxt = EV_MB;
      end
      EV_MB: begin
        acc_nxt = acc_r + prod[SW-1:0];
        ph_nxt = EV_MC;
      end
      EV_MC: begin
        acc_nxt = acc_r + prod[SW-1:0];
        ph_nxt = EV_FIN;
      end
      EV_FIN: begin
        if (s_v[SW-1]) begin
          val_nxt = 8'd0;
        end else if (|s_v[SW-1:FRAC_BITS+9]) begin
          val_nxt = 8'd255;
        end else begin
          val_nxt = s_v[FRAC_BITS+1 +: 8];
        end
        done_nxt = 1'b1;
        ph_nxt = EV_IDLE;
      end
      default: ph_nxt = EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= EV_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      done_r <= done_nxt;
    end
    dc_r <= dc_nxt;
    range_r <= range_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    t2_r <= t2_nxt;
    t3_r <= t3_nxt;
    ca_r <= ca_nxt;
    cb_r <= cb_nxt;
    cc_r <= cc_nxt;
    cd_r <= cd_nxt;
    acc_r <= acc_nxt;
    val_r <= val_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.value = val_r;

endmodule

>>> rtl/catmull_rom_tone_curve_core.sv
// Tone curve: sorted table of control points with Catmull-Rom evaluation.
// Input channel (in_valid/in_ready) carries operation, position and level;
// result channel (out_valid/out_ready) returns status and curve_value, one
// result per input transfer, in order.
// Items are processed one at a time. The point table sits in a single-port-
// write RAM with registered read; each table read is followed by a check
// state, so the scans and shifts set the run time of each item:
//   add      : scan for the position, shift the later points up one slot,
//              then write the new point
//   remove   : scan for the position, then shift the later points down
//   evaluate : segment scan, fetch of the neighbouring points, then start
//              and run the arithmetic unit (bit-serial divide, shared
//              multiplier)
//   reset op : rewrite the identity pair
// and finally the result is loaded into the output register.
// After rst_n the block writes the identity pair before
// in_ready rises. A finished result is held in the output register while the
// receiver stalls; the next item can be taken meanwhile, but its result waits
// until the held one is transferred.
module catmull_rom_tone_curve_core #(
  parameter int MAX_POINTS = tcrv_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = tcrv_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_position,
  input  logic [7:0] in_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_curve_value
);
  import tcrv_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] at_r, at_nxt;
  logic at_found_r, at_found_nxt;
  logic [CW-1:0] seg_r, seg_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] lvin_r, lvin_nxt;
  logic [7:0] prev_pos_r, prev_pos_nxt;
  logic [7:0] x1_r, x1_nxt, x2_r, x2_nxt;
  logic [7:0] lev_r [4];
  logic [7:0] lev_nxt [4];
  logic ident_r, ident_nxt;
  status_t status_r, status_nxt;
  logic [7:0] value_r, value_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [7:0] out_value_r, out_value_nxt;

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_wdata, ram_rdata;
  logic [7:0] rd_pos, rd_lev;

  eval_req_t ev_req;
  eval_rsp_t ev_rsp;

  logic match, last, full, inseg, resp_go;
  logic [CW-1:0] at_v, seg_v, lo_v, hi_v, off_w;
  logic [1:0] off_v;

  tcrv_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcrv_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ev_req),
    .rsp   (ev_rsp)
  );

  assign rd_pos = ram_rdata[15:8];
  assign rd_lev = ram_rdata[7:0];

  assign match = (rd_pos == x_r);
  assign last  = (k_r == cnt_r - CW'(1));
  assign full  = (cnt_r == CW'(MAX_POINTS));
  assign at_v  = at_found_r ? at_r : ((rd_pos > x_r) ? k_r : cnt_r);
  assign inseg = (k_r != '0) && (prev_pos_r <= x_r) && (x_r <= rd_pos);
  assign seg_v = inseg ? k_r - CW'(1) : '0;
  assign lo_v  = (seg_v == '0) ? '0 : seg_v - CW'(1);
  assign hi_v  = (seg_v == cnt_r - CW'(2)) ? seg_v + CW'(1) : seg_v + CW'(2);
  assign off_w = k_r + CW'(1) - seg_r;
  assign off_v = off_w[1:0];
  assign resp_go = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT0: state_nxt = S_INIT1;
      S_INIT1: state_nxt = ident_r ? S_RESP : S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_operation))
            OP_ADD:    state_nxt = S_A_RD;
            OP_REMOVE: state_nxt = (cnt_r <= CW'(2)) ? S_RESP : S_R_RD;
            OP_EVAL:   state_nxt = S_E_RD;
            default:   state_nxt = S_INIT0;
          endcase
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (match || (last && full)) begin
          state_nxt = S_RESP;
        end else if (last) begin
          state_nxt = (cnt_r > at_v) ? S_A_SH_RD : S_A_WR;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_A_SH_RD: state_nxt = S_A_SH_WR;
      S_A_SH_WR: state_nxt = (k_r - CW'(1) == at_r) ? S_A_WR : S_A_SH_RD;
      S_A_WR: state_nxt = S_RESP;
      S_R_RD: state_nxt = S_R_CHK;
      S_R_CHK: begin
        if (match) begin
          state_nxt = (k_r == '0 || last) ? S_RESP : S_R_SH_RD;
        end else if (last) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_R_RD;
        end
      end
      S_R_SH_RD: state_nxt = S_R_SH_WR;
      S_R_SH_WR: state_nxt = (k_r + CW'(2) < cnt_r) ? S_R_SH_RD : S_RESP;
      S_E_RD: state_nxt = S_E_CHK;
      S_E_CHK: state_nxt = (inseg || last) ? S_E_F_RD : S_E_RD;
      S_E_F_RD: state_nxt = S_E_F_CHK;
      S_E_F_CHK: state_nxt = (k_r == hi_r) ? S_E_GO : S_E_F_RD;
      S_E_GO: state_nxt = S_E_WAIT;
      S_E_WAIT: state_nxt = ev_rsp.done ? S_RESP : S_E_WAIT;
      S_RESP: state_nxt = resp_go ? S_IDLE : S_RESP;
      default: state_nxt = S_INIT0;
    endcase
  end

  // memory, handshake and arithmetic-unit controls
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = k_r[IW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = k_r[IW-1:0];
    in_ready = 1'b0;
    ev_req.start = 1'b0;
    ev_req.x  = x_r;
    ev_req.x1 = x1_r;
    ev_req.x2 = x2_r;
    ev_req.p0 = (seg_r == '0) ? lev_r[1] : lev_r[0];
    ev_req.p1 = lev_r[1];
    ev_req.p2 = lev_r[2];
    ev_req.p3 = (seg_r == cnt_r - CW'(2)) ? lev_r[2] : lev_r[3];
    case (state_r)
      S_INIT0: begin
        ram_we = 1'b1;
        ram_waddr = '0;
        ram_wdata = 16'h0000;
      end
      S_INIT1: begin
        ram_we = 1'b1;
        ram_waddr = IW'(1);
        ram_wdata = {POS_LAST, LEV_LAST};
      end
      S_IDLE: in_ready = 1'b1;
      S_A_CHK: begin
        if (match) begin
          ram_we = 1'b1;
          ram_wdata = {x_r, lvin_r};
        end
      end
      S_A_SH_RD: ram_raddr = IW'(k_r - CW'(1));
      S_A_SH_WR: ram_we = 1'b1;
      S_A_WR: begin
        ram_we = 1'b1;
        ram_waddr = at_r[IW-1:0];
        ram_wdata = {x_r, lvin_r};
      end
      S_R_SH_RD: ram_raddr = IW'(k_r + CW'(1));
      S_R_SH_WR: ram_we = 1'b1;
      S_E_GO: ev_req.start = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    k_nxt = k_r;
    cnt_nxt = cnt_r;
    at_nxt = at_r;
    at_found_nxt = at_found_r;
    seg_nxt = seg_r;
    hi_nxt = hi_r;
    x_nxt = x_r;
    lvin_nxt = lvin_r;
    prev_pos_nxt = prev_pos_r;
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    lev_nxt = lev_r;
    ident_nxt = ident_r;
    status_nxt = status_r;
    value_nxt = value_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt = out_value_r;
    case (state_r)
      S_INIT1: begin
        cnt_nxt = CW'(2);
        ident_nxt = 1'b0;
      end
      S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_position;
          lvin_nxt = in_level;
          k_nxt = '0;
          at_found_nxt = 1'b0;
          value_nxt = 8'd0;
          ident_nxt = (op_t'(in_operation) == OP_IDENT);
          status_nxt = (op_t'(in_operation) == OP_REMOVE && cnt_r <= CW'(2)) ?
                       ST_INVALID : ST_OK;
        end
      end
      S_A_CHK: begin
        if (!match) begin
          at_nxt = at_v;
          at_found_nxt = at_found_r || (rd_pos > x_r);
          k_nxt = last ? cnt_r : k_r + CW'(1);
          if (last && full) begin
            status_nxt = ST_FULL;
          end
        end
      end
      S_A_SH_WR: k_nxt = k_r - CW'(1);
      S_A_WR: cnt_nxt = cnt_r + CW'(1);
      S_R_CHK: begin
        if (match) begin
          if (k_r == '0 || last) begin
            status_nxt = ST_INVALID;
          end
        end else begin
          k_nxt = k_r + CW'(1);
          if (last) begin
            status_nxt = ST_INVALID;
          end
        end
      end
      S_R_SH_WR: begin
        k_nxt = k_r + CW'(1);
        if (!(k_r + CW'(2) < cnt_r)) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_E_CHK: begin
        prev_pos_nxt = rd_pos;
        if (inseg || last) begin
          seg_nxt = seg_v;
          hi_nxt = hi_v;
          k_nxt = lo_v;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_E_F_CHK: begin
        lev_nxt[off_v] = rd_lev;
        if (off_v == 2'd1) begin
          x1_nxt = rd_pos;
        end
        if (off_v == 2'd2) begin
          x2_nxt = rd_pos;
        end
        k_nxt = k_r + CW'(1);
      end
      S_E_WAIT: begin
        if (ev_rsp.done) begin
          value_nxt = ev_rsp.value;
        end
      end
      S_RESP: begin
        if (resp_go) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt = value_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT0;
      out_valid_r <= 1'b0;
      ident_r <= 1'b0;
      cnt_r <= CW'(2);
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ident_r <= ident_nxt;
      cnt_r <= cnt_nxt;
    end
    k_r <= k_nxt;
    at_r <= at_nxt;
    at_found_r <= at_found_nxt;
    seg_r <= seg_nxt;
    hi_r <= hi_nxt;
    x_r <= x_nxt;
    lvin_r <= lvin_nxt;
    prev_pos_r <= prev_pos_nxt;
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    lev_r <= lev_nxt;
    status_r <= status_nxt;
    value_r <= value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_curve_value = out_value_r;

endmodule
